/* src/spq_pkg.sv */
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic        [31:0] payload;
  } spq_req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_key;
    logic        [31:0] out_payload;
  } spq_rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] payload;
  } spq_entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

/* src/spq_cell.sv */
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_ctl_t   ctl,
  input  logic       occupied,
  input  logic       left_gt,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  input  spq_entry_t new_entry,
  output spq_entry_t entry,
  output logic       gt
);

  // A free slot or a strictly larger key marks where the new entry belongs.
  // Equal keys stay ahead, so equal keys leave in arrival order.
  assign gt = !occupied || ($signed(entry.key) > $signed(new_entry.key));

  always_ff @(posedge clk) begin
    if (ctl.deq) begin
      entry <= right_entry;
    end else if (ctl.enq && gt) begin
      if (left_gt) begin
        entry <= left_entry;
      end else begin
        entry <= new_entry;
      end
    end
  end

endmodule

/* src/sorted_priority_queue_core.sv */
// Sorted priority queue core.
//
// Requests arrive on the req channel (req_valid, req_stall, req). Each
// request is an enqueue of a signed key with a payload tag, or a dequeue
// of the entry with the smallest key. Every request yields exactly one
// response on the rsp channel (rsp_valid, rsp_stall, rsp) carrying a
// status: inserted, removed, empty or full. Only a removal returns a key
// and payload; all other responses carry zeros there.
//
// Storage is a row of CAPACITY cells. On each accepted request every cell
// compares its key with the incoming one in parallel and either holds,
// takes its left neighbor, takes the new entry or takes its right
// neighbor, so the whole request completes at the edge that accepts it.
// rsp is registered at that edge; rsp_valid rises in the cycle after, and
// one request is taken per cycle as long as the response side keeps up.
// The response register decouples the sides: req_stall rises only while a
// response is held and the receiver stalls it; the held response stays
// stable until taken. Reset empties the queue and drops any pending
// response; cell contents are not cleared, the entry count alone says
// which cells hold data.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  spq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output spq_rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  spq_ctl_t      ctl;
  spq_entry_t    new_entry;
  spq_entry_t    cell_entry [CAPACITY];
  logic          cell_gt    [CAPACITY];
  logic          cell_occ   [CAPACITY];
  spq_rsp_t      rsp_next;

  // A new request is refused only while a response waits on a stalled sink.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // Rejected operations (full enqueue, empty dequeue) leave the chain alone.
  assign ctl.enq = accept && (req.cmd == CMD_ENQ) && !full;
  assign ctl.deq = accept && (req.cmd == CMD_DEQ) && !empty;

  assign new_entry.key     = req.key;
  assign new_entry.payload = req.payload;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      // The first count cells hold valid, sorted data.
      assign cell_occ[i] = (count > CW'(i));

      if (i == 0) begin : g_first
        spq_cell u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .occupied    (cell_occ[i]),
          .left_gt     (1'b0),
          .left_entry  (new_entry),
          .right_entry (cell_entry[i+1]),
          .new_entry   (new_entry),
          .entry       (cell_entry[i]),
          .gt          (cell_gt[i])
        );
      end else if (i == CAPACITY - 1) begin : g_last
        spq_cell u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .occupied    (cell_occ[i]),
          .left_gt     (cell_gt[i-1]),
          .left_entry  (cell_entry[i-1]),
          .right_entry (cell_entry[i]),
          .new_entry   (new_entry),
          .entry       (cell_entry[i]),
          .gt          (cell_gt[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .occupied    (cell_occ[i]),
          .left_gt     (cell_gt[i-1]),
          .left_entry  (cell_entry[i-1]),
          .right_entry (cell_entry[i+1]),
          .new_entry   (new_entry),
          .entry       (cell_entry[i]),
          .gt          (cell_gt[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.enq) begin
      count_next = count + CW'(1);
    end else if (ctl.deq) begin
      count_next = count - CW'(1);
    end
  end

  // The head cell always holds the smallest key, so a removal reads it.
  always_comb begin
    rsp_next.out_key     = '0;
    rsp_next.out_payload = '0;
    if (req.cmd == CMD_ENQ) begin
      rsp_next.status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status      = ST_REMOVED;
      rsp_next.out_key     = cell_entry[0].key;
      rsp_next.out_payload = cell_entry[0].payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* src/spq_check.sv */
module spq_check
  import spq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input spq_req_t req,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input spq_rsp_t rsp
);

  // A held response must not change while the sink stalls it.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Requests are only held back by a stalled, pending response.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a stalled response");

  // Every accepted request produces a response on the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted request produced no response");

  // Only a removal carries a key and payload.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_REMOVED) |->
      (rsp.out_key == '0) && (rsp.out_payload == '0))
    else $error("non-removal response carries data");

endmodule

bind sorted_priority_queue_core spq_check u_spq_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 400000;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  // Tracks the sorted contents of the queue and the responses the core
  // still owes. Requests are folded in as they are accepted; responses
  // are compared in order against the oldest outstanding expectation.
  class queue_tracker;
    spq_entry_t  slots[SPQ_CAPACITY];
    int unsigned fill;
    spq_rsp_t    owed_rsp[$];
    int unsigned errors;
    int unsigned n_inserted, n_removed, n_empty, n_full, peak_fill;

    function new();
      fill = 0;
      errors = 0;
      n_inserted = 0;
      n_removed = 0;
      n_empty = 0;
      n_full = 0;
      peak_fill = 0;
    endfunction

    function int unsigned pending();
      return owed_rsp.size();
    endfunction

    function void predict_request(spq_req_t r);
      spq_rsp_t    exp;
      int unsigned pos;
      int unsigned i;
      exp = '0;
      if (r.cmd == CMD_ENQ) begin
        if (fill >= SPQ_CAPACITY) begin
          exp.status = ST_FULL;
        end else begin
          // A new entry lands behind every stored entry with an equal key.
          pos = 0;
          while (pos < fill && !($signed(slots[pos].key) > $signed(r.key))) pos++;
          for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
          slots[pos].key = r.key;
          slots[pos].payload = r.payload;
          fill++;
          if (fill > peak_fill) peak_fill = fill;
          exp.status = ST_INSERTED;
        end
      end else begin
        if (fill == 0) begin
          exp.status = ST_EMPTY;
        end else begin
          exp.status = ST_REMOVED;
          exp.out_key = slots[0].key;
          exp.out_payload = slots[0].payload;
          for (i = 1; i < fill; i++) slots[i - 1] = slots[i];
          fill--;
        end
      end
      owed_rsp.push_back(exp);
    endfunction

    function void check_response(spq_rsp_t got);
      spq_rsp_t exp;
      if (owed_rsp.size() == 0) begin
        $display("%0t: response with nothing outstanding, got %h", $time, got);
        errors++;
        return;
      end
      exp = owed_rsp.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, exp.status,
                 got.status);
        errors++;
      end
      if (got.out_key !== exp.out_key) begin
        $display("%0t: out_key mismatch: expected %0d, got %0d", $time, exp.out_key,
                 got.out_key);
        errors++;
      end
      if (got.out_payload !== exp.out_payload) begin
        $display("%0t: out_payload mismatch: expected %h, got %h", $time,
                 exp.out_payload, got.out_payload);
        errors++;
      end
      case (exp.status)
        ST_INSERTED: n_inserted++;
        ST_REMOVED:  n_removed++;
        ST_EMPTY:    n_empty++;
        default:     n_full++;
      endcase
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  spq_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  spq_rsp_t rsp;

  queue_tracker tracker;

  // Handshake between the stimulus and the receiver for the one long hold.
  bit hold_wanted;
  bit hold_done;

  int unsigned issued;
  int unsigned burst_left;
  bit          pacing_off;
  int unsigned cycle_count;

  sorted_priority_queue_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: a correct run finishes far inside this many cycles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run did not finish, %0d responses outstanding", $time,
               tracker.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // All sampling happens on the rising edge; inputs only move on the
  // falling edge, so both sides see settled values. A request accepted at
  // this edge is answered at a later edge, never at this one, so folding it
  // in before the response check keeps the order right.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) tracker.predict_request(req);
      if (rsp_valid && !rsp_stall) tracker.check_response(rsp);
    end
  end

  // Receiver: runs through stretches of no stall, light stall, heavy
  // stall and alternating stall. When the stimulus asks for it, it holds
  // off for a long fixed stretch so the response register and then the
  // request side back up.
  initial begin : receiver
    int unsigned mode;
    int unsigned stretch;
    int unsigned hold_left;
    logic        stall_next;
    rsp_stall = 1'b0;
    hold_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(8, 64);
      repeat (stretch) begin
        @(negedge clk);
        if (hold_wanted && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
          stall_next = 1'b1;
          hold_left--;
          if (hold_left == 0) hold_done = 1'b1;
        end else begin
          case (mode)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 99) < 25);
            2:       stall_next = ($urandom_range(0, 99) < 70);
            default: stall_next = ~rsp_stall;
          endcase
        end
        rsp_stall <= stall_next;
      end
    end
  end

  // Offers one request and returns once the core has taken it. The valid
  // line is left high; the next call or an idle call sets it at the next
  // falling edge.
  task automatic offer_request(input spq_req_t r);
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    issued++;
  endtask

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Sender works in bursts of random length separated by random gaps,
  // unless the current segment runs without idling.
  task automatic paced_request(input spq_req_t r);
    int unsigned gap;
    if (!pacing_off) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) idle_sender(gap);
        burst_left = $urandom_range(1, 32);
      end
      burst_left--;
    end
    offer_request(r);
  endtask

  // Stops offering and waits until every owed response has come back.
  task automatic drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  function automatic spq_req_t make_request(input logic cmd, input logic signed [31:0] k,
                                            input logic [31:0] p);
    spq_req_t r;
    r.cmd = cmd;
    r.key = k;
    r.payload = p;
    return r;
  endfunction

  // Random request. Key style 0 packs keys into a narrow band so equal
  // keys are common, 1 draws all 32 bits, 2 leans on the extremes.
  // Dequeues carry random key and payload, which the core must ignore.
  function automatic spq_req_t random_request(input int unsigned enq_pct,
                                              input int unsigned key_style);
    logic               cmd;
    logic signed [31:0] k;
    cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    case (key_style)
      0: k = $signed($urandom_range(0, 16)) - 32'sd8;
      1: k = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       k = KEY_MIN;
          1:       k = KEY_MAX;
          2:       k = KEY_MIN + $signed($urandom_range(0, 3));
          3:       k = KEY_MAX - $signed($urandom_range(0, 3));
          4:       k = -32'sd1;
          default: k = '0;
        endcase
      end
    endcase
    return make_request(cmd, k, $urandom);
  endfunction

  initial begin : stimulus
    logic signed [31:0] fill_keys[16];
    logic        [31:0] fill_pays[16];
    int unsigned        seg_len;
    int unsigned        enq_pct;
    int unsigned        key_style;
    int unsigned        i;
    bit                 pressure_done;

    tracker = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    hold_wanted = 1'b0;
    issued = 0;
    burst_left = 0;
    pacing_off = 1'b0;
    pressure_done = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A dequeue of the empty queue comes first, with the
    // largest key and an all-ones payload in the fields it should ignore.
    offer_request(make_request(CMD_DEQ, KEY_MAX, 32'hffff_ffff));

    // Fill the queue to capacity with the key extremes, zero and minus
    // one, and runs of equal keys whose payloads show arrival order.
    fill_keys = '{32'sd0, -32'sd1, 32'sd1, KEY_MIN, KEY_MAX, 32'sd5, 32'sd5, 32'sd5,
                  KEY_MIN, KEY_MAX, -32'sd5, 32'sd100, 32'sd7, 32'sd3, -32'sd100,
                  32'sd42};
    fill_pays = '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0000,
                  32'hffff_ffff, 32'h0000_000a, 32'h0000_000b, 32'h0000_000c,
                  32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0000, 32'h7fff_ffff,
                  32'h1234_5678, 32'hdead_beef, 32'h0f0f_0f0f, 32'hf0f0_f0f0};
    for (i = 0; i < 16; i++) offer_request(make_request(CMD_ENQ, fill_keys[i], fill_pays[i]));

    // One more insert must be turned away as full.
    offer_request(make_request(CMD_ENQ, -32'sd7, 32'hcafe_f00d));

    // Pull a few from the front: both minimum keys, in arrival order.
    for (i = 0; i < 5; i++) offer_request(make_request(CMD_DEQ, $urandom, $urandom));
    drain_responses();

    // Random part, in segments that each lean toward filling, draining or
    // churning the queue, so full and empty are both reached often.
    while (issued < RANDOM_ITEMS + 23) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        2:       enq_pct = 60;
        3:       enq_pct = 40;
        default: enq_pct = 50;
      endcase
      key_style = ($urandom_range(0, 9) < 5) ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
      pacing_off = ($urandom_range(0, 4) == 0);
      burst_left = 0;
      repeat (seg_len) paced_request(random_request(enq_pct, key_style));

      // About halfway, have the receiver hold off while requests keep
      // coming back to back, so the core has to stall its request side.
      if (!pressure_done && issued > RANDOM_ITEMS / 2) begin
        drain_responses();
        hold_wanted = 1'b1;
        for (i = 0; i < 24; i++) offer_request(random_request(70, 0));
        while (!hold_done) @(negedge clk);
        pressure_done = 1'b1;
        drain_responses();
      end else if ($urandom_range(0, 7) == 0) begin
        drain_responses();
      end
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) tracker.errors++;

    $display("Ran %0d requests: %0d inserted, %0d removed, %0d on empty, %0d on full.",
             issued, tracker.n_inserted, tracker.n_removed, tracker.n_empty,
             tracker.n_full);
    $display("Queue reached %0d of %0d entries; one long response hold-off was applied.",
             tracker.peak_fill, SPQ_CAPACITY);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
